// File: hw/rtl/segint_pkg.sv
package segint_pkg;

   localparam int COORD_BITS = 32;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SUB_W      = PROD_W + 1;
   localparam int N_ORIENT   = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUB_W-1:0]      sub_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   // operands of (q - p) x (r - p) = a*b - c*d
   typedef struct packed {
      diff_type a;
      diff_type b;
      diff_type c;
      diff_type d;
   } ops_type;

   typedef struct packed {
      prod_type p;
      prod_type q;
   } prods_type;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

   typedef struct packed {
      logic fdeg;
      logic sdeg;
      logic overlap;
   } flags_type;

   function automatic diff_type sub_coord(input coord_type u, input coord_type v);
      diff_type ue;
      diff_type ve;
      begin
         ue = {u[COORD_BITS-1], u};
         ve = {v[COORD_BITS-1], v};
         sub_coord = ue - ve;
      end
   endfunction

   function automatic ops_type orient_ops(input point_type p, input point_type q,
                                          input point_type r);
      ops_type o;
      begin
         o.a = sub_coord(q.x, p.x);
         o.b = sub_coord(r.y, p.y);
         o.c = sub_coord(q.y, p.y);
         o.d = sub_coord(r.x, p.x);
         orient_ops = o;
      end
   endfunction

   function automatic sign_type sign_of(input prods_type pr);
      sub_type  diff;
      sign_type s;
      begin
         diff  = {pr.p[PROD_W-1], pr.p} - {pr.q[PROD_W-1], pr.q};
         s.neg = diff[SUB_W-1];
         s.pos = !diff[SUB_W-1] && (|diff);
         sign_of = s;
      end
   endfunction

endpackage

// File: hw/rtl/segment_intersection_test_top.sv
// An item is accepted on an edge with start high and busy low; rsp_strobe marks its result.
// Throughput: one item per cycle, sustained; five register stages (input capture,
//   coordinate differences, 33x33 products, product subtract, decision).
// Reset: synchronous, active high; clears all stage valid bits, and busy is held
//   high while reset is asserted. The receiver cannot stall, so busy is otherwise low.
module segment_intersection_test_top import segint_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_first_start_x,
   input  logic signed [31:0] req_first_start_y,
   input  logic signed [31:0] req_first_end_x,
   input  logic signed [31:0] req_first_end_y,
   input  logic signed [31:0] req_second_start_x,
   input  logic signed [31:0] req_second_start_y,
   input  logic signed [31:0] req_second_end_x,
   input  logic signed [31:0] req_second_end_y,
   output logic               rsp_strobe,
   output logic               rsp_crosses
);

   // no back-pressure anywhere: only reset holds the item off
   assign busy = reset;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------- stage 1
   // capture the item; only the low COORD_BITS of each field count
   logic      v1_ff;
   point_type fs_ff, fe_ff, ss_ff, se_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      fs_ff.x <= req_first_start_x[COORD_BITS-1:0];
      fs_ff.y <= req_first_start_y[COORD_BITS-1:0];
      fe_ff.x <= req_first_end_x[COORD_BITS-1:0];
      fe_ff.y <= req_first_end_y[COORD_BITS-1:0];
      ss_ff.x <= req_second_start_x[COORD_BITS-1:0];
      ss_ff.y <= req_second_start_y[COORD_BITS-1:0];
      se_ff.x <= req_second_end_x[COORD_BITS-1:0];
      se_ff.y <= req_second_end_y[COORD_BITS-1:0];
   end

   // ---------------------------------------------------------------- stage 2
   // Orientation operands. Endpoint order within a segment only flips the sign
   // of both orientations against it, so no sorting is needed:
   //   0: second line vs first start   1: second line vs first end
   //   2: first line vs second start   3: first line vs second end
   ops_type   ops_in [N_ORIENT];
   ops_type   ops_ff [N_ORIENT];
   flags_type flags2_in;
   flags_type flags2_ff;
   logic      v2_ff;

   logic s_left_x, f_left_x, s_below_y, f_below_y;

   always_comb begin
      ops_in[0] = orient_ops(ss_ff, se_ff, fs_ff);
      ops_in[1] = orient_ops(ss_ff, se_ff, fe_ff);
      ops_in[2] = orient_ops(fs_ff, fe_ff, ss_ff);
      ops_in[3] = orient_ops(fs_ff, fe_ff, se_ff);

      // bounding boxes apart: one segment wholly left of / below the other
      s_left_x  = (ss_ff.x < fs_ff.x) && (ss_ff.x < fe_ff.x) &&
                  (se_ff.x < fs_ff.x) && (se_ff.x < fe_ff.x);
      f_left_x  = (fs_ff.x < ss_ff.x) && (fs_ff.x < se_ff.x) &&
                  (fe_ff.x < ss_ff.x) && (fe_ff.x < se_ff.x);
      s_below_y = (ss_ff.y < fs_ff.y) && (ss_ff.y < fe_ff.y) &&
                  (se_ff.y < fs_ff.y) && (se_ff.y < fe_ff.y);
      f_below_y = (fs_ff.y < ss_ff.y) && (fs_ff.y < se_ff.y) &&
                  (fe_ff.y < ss_ff.y) && (fe_ff.y < se_ff.y);

      flags2_in.overlap = !s_left_x && !f_left_x && !s_below_y && !f_below_y;
      flags2_in.fdeg    = (fs_ff == fe_ff);
      flags2_in.sdeg    = (ss_ff == se_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      ops_ff    <= ops_in;
      flags2_ff <= flags2_in;
   end

   // ---------------------------------------------------------------- stage 3
   // eight signed DIFF_W x DIFF_W products
   prods_type prods_in [N_ORIENT];
   prods_type prods_ff [N_ORIENT];
   flags_type flags3_ff;
   logic      v3_ff;

   always_comb begin
      for (int i = 0; i < N_ORIENT; i++) begin
         prods_in[i].p = ops_ff[i].a * ops_ff[i].b;
         prods_in[i].q = ops_ff[i].c * ops_ff[i].d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      prods_ff  <= prods_in;
      flags3_ff <= flags2_ff;
   end

   // ---------------------------------------------------------------- stage 4
   // exact orientation sign from a full-width subtract
   sign_type  sgn_in [N_ORIENT];
   sign_type  sgn_ff [N_ORIENT];
   flags_type flags4_ff;
   logic      v4_ff;

   always_comb begin
      for (int i = 0; i < N_ORIENT; i++) begin
         sgn_in[i] = sign_of(prods_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sgn_ff    <= sgn_in;
      flags4_ff <= flags3_ff;
   end

   // ---------------------------------------------------------------- stage 5
   // Decision. For point cases the box overlap is the bounding-box (or point
   // equality) test; collinear pairs fall back on it as well.
   logic z0, z1, z2, z3;
   logic collinear, straddle;
   logic hit_in;
   logic crosses_ff;
   logic strobe_ff;

   always_comb begin
      z0 = !sgn_ff[0].pos && !sgn_ff[0].neg;
      z1 = !sgn_ff[1].pos && !sgn_ff[1].neg;
      z2 = !sgn_ff[2].pos && !sgn_ff[2].neg;
      z3 = !sgn_ff[3].pos && !sgn_ff[3].neg;

      collinear = (z0 && z1) || (z2 && z3);
      // each segment's ends on opposite sides of, or on, the other's line
      straddle  = !((sgn_ff[0].pos && sgn_ff[1].pos) || (sgn_ff[0].neg && sgn_ff[1].neg)) &&
                  !((sgn_ff[2].pos && sgn_ff[3].pos) || (sgn_ff[2].neg && sgn_ff[3].neg));

      if (flags4_ff.fdeg && flags4_ff.sdeg) begin
         hit_in = flags4_ff.overlap;
      end else if (flags4_ff.sdeg) begin
         hit_in = z2 && flags4_ff.overlap;
      end else if (flags4_ff.fdeg) begin
         hit_in = z0 && flags4_ff.overlap;
      end else if (collinear) begin
         hit_in = flags4_ff.overlap;
      end else begin
         hit_in = straddle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      crosses_ff <= hit_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_crosses = crosses_ff;

   // ---------------------------------------------------------------- checks
   // every accepted item comes out as a result strobe
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_strobe)
      else $error("item accepted without a result five cycles on");

   // no result without a matching accepted item
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 5))
      else $error("result strobe without a matching item");

   // segments sharing their start points always meet
   a_shared_start : assert property (@(posedge clock) disable iff (reset)
      (accept &&
       (req_first_start_x[COORD_BITS-1:0] == req_second_start_x[COORD_BITS-1:0]) &&
       (req_first_start_y[COORD_BITS-1:0] == req_second_start_y[COORD_BITS-1:0]))
      |-> ##5 rsp_crosses)
      else $error("shared start point reported as no contact");

   // the stage-4 valid always turns into a strobe
   a_valid_chain : assert property (@(posedge clock) disable iff (reset)
      v4_ff |=> rsp_strobe)
      else $error("stage valid lost before the output");

endmodule
